// File: src/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Encodings for the lifecycle sequencer: phases, dispositions, event codes,
// fact bits and action bits.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int KIND_W  = 5;
    localparam int FACTS_W = 19;
    localparam int STATE_W = 5;
    localparam int DISP_W  = 3;
    localparam int ACT_W   = 15;

    typedef enum logic [STATE_W-1:0] {
        ST_STOPPED         = 5'd0,
        ST_REFUSED         = 5'd1,
        ST_FENCED          = 5'd2,
        ST_COMPLETE        = 5'd3,
        ST_REFUSED_CLEAN   = 5'd4,
        ST_TEARDOWN        = 5'd5,
        ST_BOUND           = 5'd6,
        ST_ENDPOINTS_READY = 5'd7,
        ST_RUNNER_READY    = 5'd8,
        ST_INPUT_TRANSFER  = 5'd9,
        ST_LAUNCHER_OK     = 5'd10,
        ST_CHILD_RUNNING   = 5'd11,
        ST_RESULT_OK       = 5'd12,
        ST_TRAILER_DONE    = 5'd13,
        ST_FRAME_SEEN      = 5'd14,
        ST_TERMINAL_PROOF  = 5'd15,
        ST_DURABLE_COMMIT  = 5'd16,
        ST_ABSENCE_PROVEN  = 5'd17,
        ST_CLEANUP_REQ     = 5'd18
    } phase_t;

    typedef enum logic [DISP_W-1:0] {
        DP_REFUSED  = 3'd0,
        DP_FENCED   = 3'd1,
        DP_REPLAY   = 3'd2,
        DP_TEARDOWN = 3'd3,
        DP_ADVANCED = 3'd4
    } disp_t;

    // event codes; 0..8 are faults, 26..31 unknown
    localparam logic [KIND_W-1:0] EV_FAULT_LAST  = 5'd8;
    localparam logic [KIND_W-1:0] EV_STORE_INDET = 5'd9;
    localparam logic [KIND_W-1:0] EV_RESP_LOST   = 5'd10;
    localparam logic [KIND_W-1:0] EV_BIND        = 5'd11;
    localparam logic [KIND_W-1:0] EV_ENDPOINTS   = 5'd12;
    localparam logic [KIND_W-1:0] EV_DRAINS      = 5'd13;
    localparam logic [KIND_W-1:0] EV_RUNNER      = 5'd14;
    localparam logic [KIND_W-1:0] EV_INPUTS      = 5'd15;
    localparam logic [KIND_W-1:0] EV_CHILD       = 5'd16;
    localparam logic [KIND_W-1:0] EV_RESULT      = 5'd17;
    localparam logic [KIND_W-1:0] EV_TRAILER     = 5'd18;
    localparam logic [KIND_W-1:0] EV_FRAME       = 5'd19;
    localparam logic [KIND_W-1:0] EV_TERMINAL    = 5'd20;
    localparam logic [KIND_W-1:0] EV_DURABLE     = 5'd21;
    localparam logic [KIND_W-1:0] EV_DELIVERED   = 5'd22;
    localparam logic [KIND_W-1:0] EV_TD_CONF     = 5'd23;
    localparam logic [KIND_W-1:0] EV_ABS_CONF    = 5'd24;
    localparam logic [KIND_W-1:0] EV_CLEAN_CONF  = 5'd25;

    // required fact sets
    localparam logic [FACTS_W-1:0] NEED_BIND      = 19'h0000F;
    localparam logic [FACTS_W-1:0] NEED_ENDPOINTS = 19'h00200;
    localparam logic [FACTS_W-1:0] NEED_DRAINS    = 19'h00400;
    localparam logic [FACTS_W-1:0] NEED_INPUTS    = 19'h03800;
    localparam logic [FACTS_W-1:0] NEED_RESULT    = 19'h04000;
    localparam logic [FACTS_W-1:0] NEED_TRAILER   = 19'h08000;
    localparam logic [FACTS_W-1:0] NEED_FRAME     = 19'h10000;
    localparam logic [FACTS_W-1:0] NEED_TERMINAL  = 19'h001F0;
    localparam logic [FACTS_W-1:0] NEED_DURABLE   = 19'h20000;
    localparam logic [FACTS_W-1:0] NEED_TD_CONF   = 19'h00080;
    localparam logic [FACTS_W-1:0] NEED_ABS_CONF  = 19'h00050;
    localparam logic [FACTS_W-1:0] NEED_CLEAN     = 19'h40000;

    // action bits
    localparam logic [ACT_W-1:0] AC_NONE          = 15'h0000;
    localparam logic [ACT_W-1:0] AC_STOP_MISMATCH = 15'h0001;
    localparam logic [ACT_W-1:0] AC_FENCE_STORE   = 15'h0002;
    localparam logic [ACT_W-1:0] AC_REQ_TEARDOWN  = 15'h0004;
    localparam logic [ACT_W-1:0] AC_REPLAY_STORED = 15'h0008;
    localparam logic [ACT_W-1:0] AC_CREATE_EPS    = 15'h0010;
    localparam logic [ACT_W-1:0] AC_START_DRAINS  = 15'h0020;
    localparam logic [ACT_W-1:0] AC_START_RUNNER  = 15'h0040;
    localparam logic [ACT_W-1:0] AC_WRITE_SOURCE  = 15'h0080;
    localparam logic [ACT_W-1:0] AC_WRITE_INPUT   = 15'h0100;
    localparam logic [ACT_W-1:0] AC_CLOSE_WRITERS = 15'h0200;
    localparam logic [ACT_W-1:0] AC_ALLOW_CHILD   = 15'h0400;
    localparam logic [ACT_W-1:0] AC_REQ_DURABLE   = 15'h0800;
    localparam logic [ACT_W-1:0] AC_DELIVER_STORE = 15'h1000;
    localparam logic [ACT_W-1:0] AC_PROVE_ABSENCE = 15'h2000;
    localparam logic [ACT_W-1:0] AC_REMOVE_ROOT   = 15'h4000;

endpackage

// File: src/lifecycle_sequencer_with_fencing.sv
// An accepted word has its result registered and shown from the next cycle on.
// Throughput: one word per cycle while out_ready is high; the output register is refilled whenever it is
// empty or being taken, so input and output run back to back.
// The combinational phase decode sets the rate.
// Reset (rst_n low, asynchronous): phase stopped, durable flag clear, output empty.
// ----------------------------------------------------------------------------
// lifecycle_sequencer_with_fencing
// Lifecycle phase sequencer with store fencing: decodes one event word per
// cycle while the output register is free or being taken, against the
// current phase and facts, and registers the new phase, disposition and actions.
// ----------------------------------------------------------------------------
module lifecycle_sequencer_with_fencing (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lsf_pkg::KIND_W-1:0]    kind,
    input  logic [lsf_pkg::FACTS_W-1:0]   facts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsf_pkg::STATE_W-1:0]   next_state,
    output logic [lsf_pkg::DISP_W-1:0]    disposition,
    output logic [lsf_pkg::ACT_W-1:0]     actions
);
    import lsf_pkg::*;

    phase_t             phase_reg, phase_next;
    logic               durable_reg, durable_next;
    logic               out_valid_reg, out_valid_next;
    phase_t             state_out_reg;
    disp_t              disp_out_reg, disp_next;
    logic [ACT_W-1:0]   act_out_reg, act_next;
    logic               in_fire;
    logic               faulted;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign faulted  = (kind <= EV_FAULT_LAST) || (kind == EV_RESP_LOST && !durable_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ST_STOPPED;
            durable_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                phase_reg   <= phase_next;
                durable_reg <= durable_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            state_out_reg <= phase_next;
            disp_out_reg  <= disp_next;
            act_out_reg   <= act_next;
        end
    end

    always_comb
    begin
        out_valid_next = in_fire ? 1'b1 : (out_valid_reg && !out_ready);
        durable_next   = durable_reg;
        // default: no match refuses
        phase_next     = ST_REFUSED;
        disp_next      = DP_REFUSED;
        act_next       = AC_STOP_MISMATCH;

        if (kind == EV_STORE_INDET)
        begin
            durable_next = 1'b0;
            phase_next   = ST_FENCED;
            disp_next    = DP_FENCED;
            act_next     = AC_FENCE_STORE | AC_REQ_TEARDOWN;
        end
        else if (phase_reg == ST_COMPLETE)
        begin
            phase_next = ST_COMPLETE;
            if (kind == EV_RESP_LOST && durable_reg)
            begin
                disp_next = DP_REPLAY;
                act_next  = AC_REPLAY_STORED;
            end
        end
        else if (phase_reg == ST_FENCED)
        begin
            phase_next = ST_FENCED;
            disp_next  = DP_FENCED;
            act_next   = AC_FENCE_STORE;
        end
        else if (phase_reg == ST_REFUSED_CLEAN || phase_reg == ST_REFUSED)
        begin
            phase_next = phase_reg;
        end
        else if (faulted)
        begin
            phase_next = ST_TEARDOWN;
            disp_next  = DP_TEARDOWN;
            act_next   = AC_REQ_TEARDOWN;
        end
        else
        begin
            unique case (phase_reg)
                ST_STOPPED:
                    if (kind == EV_BIND && (facts & NEED_BIND) == NEED_BIND)
                    begin
                        phase_next = ST_BOUND;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_CREATE_EPS;
                    end
                ST_BOUND:
                    if (kind == EV_ENDPOINTS && (facts & NEED_ENDPOINTS) == NEED_ENDPOINTS)
                    begin
                        phase_next = ST_ENDPOINTS_READY;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_START_DRAINS;
                    end
                ST_ENDPOINTS_READY:
                    if (kind == EV_DRAINS && (facts & NEED_DRAINS) == NEED_DRAINS)
                    begin
                        phase_next = ST_RUNNER_READY;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_START_RUNNER;
                    end
                ST_RUNNER_READY:
                    if (kind == EV_RUNNER)
                    begin
                        phase_next = ST_INPUT_TRANSFER;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_WRITE_SOURCE | AC_WRITE_INPUT;
                    end
                ST_INPUT_TRANSFER:
                    if (kind == EV_INPUTS && (facts & NEED_INPUTS) == NEED_INPUTS)
                    begin
                        phase_next = ST_LAUNCHER_OK;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_CLOSE_WRITERS | AC_ALLOW_CHILD;
                    end
                ST_LAUNCHER_OK:
                    if (kind == EV_CHILD)
                    begin
                        phase_next = ST_CHILD_RUNNING;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_NONE;
                    end
                ST_CHILD_RUNNING:
                    if (kind == EV_RESULT && (facts & NEED_RESULT) == NEED_RESULT)
                    begin
                        phase_next = ST_RESULT_OK;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_NONE;
                    end
                ST_RESULT_OK:
                    if (kind == EV_TRAILER && (facts & NEED_TRAILER) == NEED_TRAILER)
                    begin
                        phase_next = ST_TRAILER_DONE;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_NONE;
                    end
                ST_TRAILER_DONE:
                    if (kind == EV_FRAME && (facts & NEED_FRAME) == NEED_FRAME)
                    begin
                        phase_next = ST_FRAME_SEEN;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_NONE;
                    end
                ST_FRAME_SEEN:
                    if (kind == EV_TERMINAL && (facts & NEED_TERMINAL) == NEED_TERMINAL)
                    begin
                        phase_next = ST_TERMINAL_PROOF;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_REQ_DURABLE;
                    end
                ST_TERMINAL_PROOF:
                    if (kind == EV_DURABLE && (facts & NEED_DURABLE) == NEED_DURABLE)
                    begin
                        durable_next = 1'b1;
                        phase_next   = ST_DURABLE_COMMIT;
                        disp_next    = DP_ADVANCED;
                        act_next     = AC_DELIVER_STORE;
                    end
                ST_DURABLE_COMMIT:
                    if (kind == EV_DELIVERED)
                    begin
                        phase_next = ST_COMPLETE;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_NONE;
                    end
                    else if (kind == EV_RESP_LOST && durable_reg)
                    begin
                        phase_next = ST_COMPLETE;
                        disp_next  = DP_REPLAY;
                        act_next   = AC_REPLAY_STORED;
                    end
                ST_TEARDOWN:
                    if (kind == EV_TD_CONF && (facts & NEED_TD_CONF) == NEED_TD_CONF)
                    begin
                        phase_next = ST_ABSENCE_PROVEN;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_PROVE_ABSENCE;
                    end
                ST_ABSENCE_PROVEN:
                    if (kind == EV_ABS_CONF && (facts & NEED_ABS_CONF) == NEED_ABS_CONF)
                    begin
                        phase_next = ST_CLEANUP_REQ;
                        disp_next  = DP_ADVANCED;
                        act_next   = AC_REMOVE_ROOT;
                    end
                ST_CLEANUP_REQ:
                    // cleanup ends in the quiet refused phase with no action
                    if (kind == EV_CLEAN_CONF && (facts & NEED_CLEAN) == NEED_CLEAN)
                    begin
                        phase_next = ST_REFUSED_CLEAN;
                        disp_next  = DP_REFUSED;
                        act_next   = AC_NONE;
                    end
                default:
                begin
                    phase_next = ST_REFUSED;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_state  = state_out_reg;
    assign disposition = disp_out_reg;
    assign actions     = act_out_reg;

`ifndef ASSERT_OFF
    a_fence_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && kind == EV_STORE_INDET |=> phase_reg == ST_FENCED && !durable_reg)
        else $error("store fence did not fence or clear durable");

    a_complete_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == ST_COMPLETE && kind != EV_STORE_INDET
        |=> phase_reg == ST_COMPLETE)
        else $error("complete phase left without fence");

    a_replay_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && disp_out_reg == DP_REPLAY |-> state_out_reg == ST_COMPLETE)
        else $error("replay outside complete");

    a_durable_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(durable_reg) |-> phase_reg == ST_DURABLE_COMMIT)
        else $error("durable flag set outside durable commit");

    a_out_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_out_reg == phase_reg)
        else $error("registered state differs from phase");
`endif

endmodule

// File: tb/lifecycle_outcome_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifecycle_outcome_checker
// Watches the event and result channels of the lifecycle sequencer. For every
// accepted event word it computes the new phase, disposition and actions. Each
// accepted result is compared in order against the oldest outstanding one.
// ----------------------------------------------------------------------------
module lifecycle_outcome_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [lsf_pkg::KIND_W-1:0]    kind,
    input  logic [lsf_pkg::FACTS_W-1:0]   facts,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [lsf_pkg::STATE_W-1:0]   next_state,
    input  logic [lsf_pkg::DISP_W-1:0]    disposition,
    input  logic [lsf_pkg::ACT_W-1:0]     actions,
    output int                            errors,
    output int                            pending,
    output int                            checked
);
    import lsf_pkg::*;

    typedef struct packed {
        phase_t             st;
        disp_t              dp;
        logic [ACT_W-1:0]   act;
    } outcome_t;

    phase_t   life_phase;
    logic     durable_seen;
    outcome_t outcomes_due[$];

    function automatic logic has_facts(input logic [FACTS_W-1:0] f,
                                       input logic [FACTS_W-1:0] need);
        return (f & need) == need;
    endfunction

    function automatic outcome_t make_outcome(input phase_t s, input disp_t d,
                                              input logic [ACT_W-1:0] a);
        outcome_t o;
        o.st  = s;
        o.dp  = d;
        o.act = a;
        return o;
    endfunction

    // New phase, disposition and actions for one event in phase cur.
    function automatic outcome_t decide_event(input phase_t cur, input logic dur,
                                              input logic [KIND_W-1:0] k,
                                              input logic [FACTS_W-1:0] f,
                                              output logic dur_next);
        outcome_t o;
        dur_next = dur;
        o = make_outcome(ST_REFUSED, DP_REFUSED, AC_STOP_MISMATCH);
        if (k == EV_STORE_INDET)
        begin
            dur_next = 1'b0;
            o = make_outcome(ST_FENCED, DP_FENCED, AC_FENCE_STORE | AC_REQ_TEARDOWN);
        end
        else if (cur == ST_COMPLETE)
        begin
            if (k == EV_RESP_LOST && dur)
                o = make_outcome(ST_COMPLETE, DP_REPLAY, AC_REPLAY_STORED);
            else
                o = make_outcome(ST_COMPLETE, DP_REFUSED, AC_STOP_MISMATCH);
        end
        else if (cur == ST_FENCED)
            o = make_outcome(ST_FENCED, DP_FENCED, AC_FENCE_STORE);
        else if (cur == ST_REFUSED || cur == ST_REFUSED_CLEAN)
            o = make_outcome(cur, DP_REFUSED, AC_STOP_MISMATCH);
        else if (k <= EV_FAULT_LAST || (k == EV_RESP_LOST && !dur))
            o = make_outcome(ST_TEARDOWN, DP_TEARDOWN, AC_REQ_TEARDOWN);
        else
        begin
            case (cur)
                ST_STOPPED:
                    if (k == EV_BIND && has_facts(f, NEED_BIND))
                        o = make_outcome(ST_BOUND, DP_ADVANCED, AC_CREATE_EPS);
                ST_BOUND:
                    if (k == EV_ENDPOINTS && has_facts(f, NEED_ENDPOINTS))
                        o = make_outcome(ST_ENDPOINTS_READY, DP_ADVANCED, AC_START_DRAINS);
                ST_ENDPOINTS_READY:
                    if (k == EV_DRAINS && has_facts(f, NEED_DRAINS))
                        o = make_outcome(ST_RUNNER_READY, DP_ADVANCED, AC_START_RUNNER);
                ST_RUNNER_READY:
                    if (k == EV_RUNNER)
                        o = make_outcome(ST_INPUT_TRANSFER, DP_ADVANCED,
                                         AC_WRITE_SOURCE | AC_WRITE_INPUT);
                ST_INPUT_TRANSFER:
                    if (k == EV_INPUTS && has_facts(f, NEED_INPUTS))
                        o = make_outcome(ST_LAUNCHER_OK, DP_ADVANCED,
                                         AC_CLOSE_WRITERS | AC_ALLOW_CHILD);
                ST_LAUNCHER_OK:
                    if (k == EV_CHILD)
                        o = make_outcome(ST_CHILD_RUNNING, DP_ADVANCED, AC_NONE);
                ST_CHILD_RUNNING:
                    if (k == EV_RESULT && has_facts(f, NEED_RESULT))
                        o = make_outcome(ST_RESULT_OK, DP_ADVANCED, AC_NONE);
                ST_RESULT_OK:
                    if (k == EV_TRAILER && has_facts(f, NEED_TRAILER))
                        o = make_outcome(ST_TRAILER_DONE, DP_ADVANCED, AC_NONE);
                ST_TRAILER_DONE:
                    if (k == EV_FRAME && has_facts(f, NEED_FRAME))
                        o = make_outcome(ST_FRAME_SEEN, DP_ADVANCED, AC_NONE);
                ST_FRAME_SEEN:
                    if (k == EV_TERMINAL && has_facts(f, NEED_TERMINAL))
                        o = make_outcome(ST_TERMINAL_PROOF, DP_ADVANCED, AC_REQ_DURABLE);
                ST_TERMINAL_PROOF:
                    if (k == EV_DURABLE && has_facts(f, NEED_DURABLE))
                    begin
                        dur_next = 1'b1;
                        o = make_outcome(ST_DURABLE_COMMIT, DP_ADVANCED, AC_DELIVER_STORE);
                    end
                ST_DURABLE_COMMIT:
                    if (k == EV_DELIVERED)
                        o = make_outcome(ST_COMPLETE, DP_ADVANCED, AC_NONE);
                    else if (k == EV_RESP_LOST && dur)
                        o = make_outcome(ST_COMPLETE, DP_REPLAY, AC_REPLAY_STORED);
                ST_TEARDOWN:
                    if (k == EV_TD_CONF && has_facts(f, NEED_TD_CONF))
                        o = make_outcome(ST_ABSENCE_PROVEN, DP_ADVANCED, AC_PROVE_ABSENCE);
                ST_ABSENCE_PROVEN:
                    if (k == EV_ABS_CONF && has_facts(f, NEED_ABS_CONF))
                        o = make_outcome(ST_CLEANUP_REQ, DP_ADVANCED, AC_REMOVE_ROOT);
                ST_CLEANUP_REQ:
                    if (k == EV_CLEAN_CONF && has_facts(f, NEED_CLEAN))
                        o = make_outcome(ST_REFUSED_CLEAN, DP_REFUSED, AC_NONE);
                default:
                    o = make_outcome(ST_REFUSED, DP_REFUSED, AC_STOP_MISMATCH);
            endcase
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        outcome_t want;
        logic     dur_next;
        if (!rst_n)
        begin
            life_phase   = ST_STOPPED;
            durable_seen = 1'b0;
            outcomes_due.delete();
            errors  = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            // pop before push: a result never belongs to the word taken at this edge
            if (out_valid && out_ready)
            begin
                checked++;
                if (outcomes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing outstanding: next_state %0d",
                             $time, next_state,
                             " disposition %0d actions %h", disposition, actions);
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (next_state !== want.st)
                    begin
                        errors++;
                        $display("%0t: next_state expected %0d actual %0d",
                                 $time, want.st, next_state);
                    end
                    if (disposition !== want.dp)
                    begin
                        errors++;
                        $display("%0t: disposition expected %0d actual %0d",
                                 $time, want.dp, disposition);
                    end
                    if (actions !== want.act)
                    begin
                        errors++;
                        $display("%0t: actions expected %h actual %h",
                                 $time, want.act, actions);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = decide_event(life_phase, durable_seen, kind, facts, dur_next);
                life_phase   = want.st;
                durable_seen = dur_next;
                outcomes_due.push_back(want);
            end
            pending = outcomes_due.size();
        end
    end

endmodule

// File: tb/tb_lifecycle_sequencer_with_fencing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifecycle_sequencer_with_fencing
// Walks the sequencer along one lifecycle route per seed: the forward chain,
// then either commit and replay or a long fault and teardown loop, then the
// sticky refusal and fencing phases. Both channels idle and stall at random;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lifecycle_sequencer_with_fencing;
    import lsf_pkg::*;

    localparam int RANDOM_WORDS = 1300;
    localparam int TAIL_WORDS   = 24;

    localparam logic [KIND_W-1:0]  EV_CANCEL        = 5'd0;
    localparam logic [KIND_W-1:0]  EV_UNKNOWN_FIRST = 5'd26;
    localparam logic [KIND_W-1:0]  EV_UNKNOWN_LAST  = 5'd31;
    localparam logic [FACTS_W-1:0] NO_FACTS         = '0;
    localparam logic [FACTS_W-1:0] ALL_FACTS        = '1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [KIND_W-1:0]    kind      = '0;
    logic [FACTS_W-1:0]   facts     = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATE_W-1:0]   next_state;
    logic [DISP_W-1:0]    disposition;
    logic [ACT_W-1:0]     actions;

    int errors;
    int pending;
    int checked;
    int sent = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int td_stage;
    bit route_commit;

    // idling per block of 100 words: none, sender, receiver, both
    int idle_in_tab[4]  = '{0, 67, 0, 32};
    int idle_out_tab[4] = '{0, 0, 67, 32};

    logic [KIND_W-1:0] fwd_kind[12] = '{EV_BIND, EV_ENDPOINTS, EV_DRAINS, EV_RUNNER,
                                        EV_INPUTS, EV_CHILD, EV_RESULT, EV_TRAILER,
                                        EV_FRAME, EV_TERMINAL, EV_DURABLE, EV_DELIVERED};
    logic [FACTS_W-1:0] fwd_need[12] = '{NEED_BIND, NEED_ENDPOINTS, NEED_DRAINS, NO_FACTS,
                                         NEED_INPUTS, NO_FACTS, NEED_RESULT, NEED_TRAILER,
                                         NEED_FRAME, NEED_TERMINAL, NEED_DURABLE, NO_FACTS};
    logic [KIND_W-1:0]  td_kind[3] = '{EV_TD_CONF, EV_ABS_CONF, EV_CLEAN_CONF};
    logic [FACTS_W-1:0] td_need[3] = '{NEED_TD_CONF, NEED_ABS_CONF, NEED_CLEAN};

    lifecycle_sequencer_with_fencing i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .facts       (facts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .next_state  (next_state),
        .disposition (disposition),
        .actions     (actions)
    );

    lifecycle_outcome_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .facts       (facts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .next_state  (next_state),
        .disposition (disposition),
        .actions     (actions),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= out_stall_pct);

    initial
    begin
        #2000000;
        $display("tb_lifecycle_sequencer_with_fencing: errors");
        $finish;
    end

    function automatic logic [FACTS_W-1:0] rand_facts();
        int unsigned r;
        r = $urandom;
        return r[FACTS_W-1:0];
    endfunction

    function automatic logic [KIND_W-1:0] rand_kind(input int lo, input int hi);
        int unsigned r;
        r = $urandom_range(hi, lo);
        return r[KIND_W-1:0];
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] k, input logic [FACTS_W-1:0] f);
        in_idle_pct   = idle_in_tab[(sent / 100) % 4];
        out_stall_pct = idle_out_tab[(sent / 100) % 4];
        // idle with junk on the payload
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            kind     <= rand_kind(0, 31);
            facts    <= rand_facts();
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        facts    <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [KIND_W-1:0] k;
        int                ending;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // forward chain up to frame seen, with exact, full and empty fact sets
        send_word(fwd_kind[0], fwd_need[0]);
        send_word(fwd_kind[1], ALL_FACTS);
        for (int i = 2; i < 9; i++)
            send_word(fwd_kind[i], (i == 3) ? NO_FACTS : (fwd_need[i] | rand_facts()));

        // sticky phases leave only for the fenced phase or on reset, so each seed picks one route
        route_commit = 1'($urandom_range(1));
        if (route_commit)
        begin
            send_word(EV_TERMINAL, NEED_TERMINAL);
            send_word(EV_DURABLE, NEED_DURABLE | rand_facts());
            if ($urandom_range(1))
                send_word(EV_DELIVERED, rand_facts());
            else
                send_word(EV_RESP_LOST, rand_facts());
            send_word(EV_RESP_LOST, ALL_FACTS);
            send_word(EV_DELIVERED, NO_FACTS);
            send_word(EV_CANCEL, rand_facts());
            send_word(EV_UNKNOWN_LAST, ALL_FACTS);
            // hold in complete: replay on lost responses, refuse the rest
            for (int n = 0; n < RANDOM_WORDS; n++)
            begin
                k = ($urandom_range(99) < 30) ? EV_RESP_LOST : rand_kind(0, 31);
                if (k == EV_STORE_INDET)
                    k = EV_RESP_LOST;
                send_word(k, rand_facts());
            end
            wait_drained();
        end
        else
        begin
            send_word(EV_FAULT_LAST, rand_facts());
            send_word(EV_CANCEL, ALL_FACTS);
            send_word(EV_RESP_LOST, NO_FACTS);
            send_word(EV_TD_CONF, NEED_TD_CONF);
            send_word(EV_ABS_CONF, ALL_FACTS);
            send_word(rand_kind(int'(EV_CANCEL), int'(EV_FAULT_LAST)), rand_facts());
            td_stage = 0;
            // cycle teardown -> absence -> cleanup, with faults pulling back
            for (int n = 0; n < RANDOM_WORDS; n++)
            begin
                if (td_stage < 2 && $urandom_range(99) < 70)
                begin
                    send_word(td_kind[td_stage], td_need[td_stage] | rand_facts());
                    td_stage++;
                end
                else
                begin
                    k = ($urandom_range(9) == 0)
                        ? EV_RESP_LOST
                        : rand_kind(int'(EV_CANCEL), int'(EV_FAULT_LAST));
                    send_word(k, rand_facts());
                    td_stage = 0;
                end
            end
            wait_drained();
            // leave the loop: clean finish, unknown event, or a step short of facts
            ending = $urandom_range(2);
            if (ending == 0)
            begin
                while (td_stage < 3)
                begin
                    send_word(td_kind[td_stage], td_need[td_stage] | rand_facts());
                    td_stage++;
                end
            end
            else if (ending == 1)
                send_word(rand_kind(int'(EV_UNKNOWN_FIRST), int'(EV_UNKNOWN_LAST)),
                          rand_facts());
            else
                send_word(td_kind[td_stage], rand_facts() & ~td_need[td_stage]);
        end

        // sticky refusal or complete, then fence and hold fenced
        for (int n = 0; n < TAIL_WORDS; n++)
        begin
            if (n == TAIL_WORDS / 2)
                send_word(EV_STORE_INDET, rand_facts());
            else
            begin
                k = rand_kind(0, 31);
                if (n < TAIL_WORDS / 2 && k == EV_STORE_INDET)
                    k = EV_UNKNOWN_LAST;
                send_word(k, rand_facts());
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Run covered %0d event words on the %s route; %0d results checked.",
                 sent, route_commit ? "commit and replay" : "fault and teardown", checked);
        if (errors == 0)
            $display("tb_lifecycle_sequencer_with_fencing: clean");
        else
            $display("tb_lifecycle_sequencer_with_fencing: errors");
        $finish;
    end

endmodule

// File: filelist.f
src/lsf_pkg.sv
src/lifecycle_sequencer_with_fencing.sv
tb/lifecycle_outcome_checker.sv
tb/tb_lifecycle_sequencer_with_fencing.sv
